### sv/isc_pkg.sv
package isc_pkg;

  // width of a count and the prime it is reduced by
  localparam int unsigned COUNT_W = 30;
  localparam logic [COUNT_W-1:0] MODULUS = 30'd1000000007;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_COUNT,
    ST_UPDATE,
    ST_TOTAL,
    ST_EMIT
  } isc_state_e;

endpackage

### sv/isc_if.sv
// input channel: one sequence element per item
interface isc_in_if #(
  parameter int unsigned VALUE_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

// output channel: one count per sequence
interface isc_out_if;
  logic                         valid;
  logic                         ready;
  logic [isc_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output count, input ready);
  modport sink (input valid, input count, output ready);
endinterface

### sv/increasing_subsequence_counter_core.sv
// Counts strictly increasing subsequences of a value stream, modulo 1000000007.
// in_i carries one element per item (value, last); out_o carries one
// count per sequence, given on the item with last set. Both are valid/ready.
// Per level of a value-indexed tree of partial sums, the sequencer reads at most
// one entry to form the prefix sum, then read-modify-writes one entry per level;
// a single modular adder does every addition, one a cycle.
// While an item is processed ready stays low; how long it occupies the block
// is set by the one read and one write port of the sum memory and the shared
// adder. On an item with last set, ST_TOTAL is followed by ST_EMIT, which
// loads the count into the output register once the previous one is taken.
// After reset, and after every item with last set, the memory is swept to
// zero, one entry a cycle, all 2^(VALUE_BITS+1)-1 entries (2047 by default),
// with ready low meanwhile. The running total is cleared at the same time.
// The count sits in an output register until taken; a stalled receiver only
// holds back the next count, further items of the new sequence are accepted.
module increasing_subsequence_counter_core #(
  parameter int unsigned VALUE_BITS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  isc_in_if.sink          in_i,
  isc_out_if.source       out_o
);
  import isc_pkg::*;

  localparam int unsigned DEPTH  = (1 << (VALUE_BITS + 1)) - 1;
  localparam int unsigned ADDR_W = VALUE_BITS + 1;
  localparam int unsigned IDX_W  = VALUE_BITS + 2;
  localparam int unsigned LVL_W  = $clog2(VALUE_BITS + 2);
  localparam logic [LVL_W-1:0]   TOP_LVL = LVL_W'(VALUE_BITS);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0]   DEPTH_IDX = IDX_W'(DEPTH);
  localparam logic signed [VALUE_BITS:0] X_ONE = 1;

  isc_state_e state_q, state_d;

  logic [ADDR_W-1:0]          clr_addr_q, clr_addr_d;
  logic signed [VALUE_BITS:0] x_q, x_d;
  logic [LVL_W-1:0]           lvl_q, lvl_d;
  logic [VALUE_BITS-1:0]      v_q, v_d;
  logic                       last_q, last_d;
  logic                       pend_q, pend_d;
  logic [ADDR_W-1:0]          waddr_q, waddr_d;
  logic [COUNT_W-1:0]         sum_q, sum_d;
  logic [COUNT_W-1:0]         cnt_q, cnt_d;
  logic [COUNT_W-1:0]         total_q, total_d;
  logic                       out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]         out_count_q, out_count_d;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [COUNT_W-1:0]         mem_wdata;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [COUNT_W-1:0]         mem_rdata;

  logic [COUNT_W-1:0]         add_a, add_b, add_sum;

  logic                       q_issue;
  logic [IDX_W-1:0]           q_idx;
  logic [IDX_W-1:0]           u_idx;

  // first entry of a tree level
  function automatic logic [IDX_W-1:0] base_f(input logic [LVL_W-1:0] lvl);
    logic [LVL_W-1:0] sh;
    sh = LVL_W'(VALUE_BITS + 1) - lvl;
    return (IDX_W'(1) << (VALUE_BITS + 1)) - (IDX_W'(1) << sh);
  endfunction

  isc_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  isc_addmod u_addmod (
    .a_i   (add_a),
    .b_i   (add_b),
    .sum_o (add_sum)
  );

  // tree addresses for the prefix walk and for the update walk
  always_comb begin
    q_issue = !x_q[VALUE_BITS] && (lvl_q <= TOP_LVL);
    if (x_q[0]) begin
      q_idx = base_f(LVL_W'(lvl_q + 1'b1)) + IDX_W'($unsigned(x_q[VALUE_BITS:1]));
    end else begin
      q_idx = base_f(lvl_q) + IDX_W'($unsigned(x_q));
    end
    u_idx = base_f(lvl_q) + IDX_W'(v_q >> lvl_q);
  end

  // operand selection for the shared adder
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_q)
      ST_QUERY: begin
        add_a = sum_q;
        add_b = mem_rdata;
      end
      ST_COUNT: begin
        add_a = COUNT_W'(1);
        add_b = sum_q;
      end
      ST_UPDATE: begin
        add_a = mem_rdata;
        add_b = cnt_q;
      end
      ST_TOTAL: begin
        add_a = total_q;
        add_b = cnt_q;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  // sequencer: next state and datapath controls
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    x_d         = x_q;
    lvl_d       = lvl_q;
    v_d         = v_q;
    last_d      = last_q;
    pend_d      = pend_q;
    waddr_d     = waddr_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    mem_we      = 1'b0;
    mem_waddr   = waddr_q;
    mem_wdata   = add_sum;
    mem_raddr   = u_idx[ADDR_W-1:0];

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
        total_d   = '0;
        if (clr_addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          v_d     = in_i.value;
          last_d  = in_i.last;
          x_d     = $signed({1'b0, in_i.value}) - X_ONE;
          lvl_d   = '0;
          pend_d  = 1'b0;
          sum_d   = '0;
          state_d = ST_QUERY;
        end
      end
      ST_QUERY: begin
        mem_raddr = q_idx[ADDR_W-1:0];
        pend_d    = 1'b0;
        if (q_issue) begin
          pend_d = (q_idx < DEPTH_IDX);
          x_d    = (x_q >>> 1) - X_ONE;
          lvl_d  = LVL_W'(lvl_q + 1'b1);
        end
        if (pend_q) begin
          sum_d = add_sum;
        end
        if (!q_issue && !pend_q) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cnt_d   = add_sum;
        lvl_d   = '0;
        pend_d  = 1'b0;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        pend_d = 1'b0;
        if (lvl_q <= TOP_LVL) begin
          waddr_d = u_idx[ADDR_W-1:0];
          pend_d  = 1'b1;
          lvl_d   = LVL_W'(lvl_q + 1'b1);
        end
        if (pend_q) begin
          mem_we = 1'b1;
        end
        if (!(lvl_q <= TOP_LVL) && !pend_q) begin
          state_d = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        total_d = add_sum;
        if (last_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_count_d = total_q;
          total_d     = '0;
          clr_addr_d  = '0;
          state_d     = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      lvl_q       <= '0;
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      x_q         <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_addr_q  <= clr_addr_d;
      lvl_q       <= lvl_d;
      pend_q      <= pend_d;
      last_q      <= last_d;
      x_q         <= x_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    waddr_q     <= waddr_d;
    sum_q       <= sum_d;
    cnt_q       <= cnt_d;
    out_count_q <= out_count_d;
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.count = out_count_q;

endmodule

### sv/isc_addmod.sv
module isc_addmod (
  input  logic [isc_pkg::COUNT_W-1:0] a_i,
  input  logic [isc_pkg::COUNT_W-1:0] b_i,
  output logic [isc_pkg::COUNT_W-1:0] sum_o
);
  import isc_pkg::*;

  logic [COUNT_W:0] raw;
  logic [COUNT_W:0] reduced;

  // add and fold back once, both operands are already below the modulus
  always_comb begin
    raw     = {1'b0, a_i} + {1'b0, b_i};
    reduced = raw - {1'b0, MODULUS};
    if (raw >= {1'b0, MODULUS}) begin
      sum_o = reduced[COUNT_W-1:0];
    end else begin
      sum_o = raw[COUNT_W-1:0];
    end
  end

endmodule

### sv/isc_store.sv
module isc_store #(
  parameter int unsigned ADDR_W = 11,
  parameter int unsigned DATA_W = 30,
  parameter int unsigned DEPTH  = 2047
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
